// ===== src/assert_macros.svh =====
// assertion macros included by sm4_block_cipher_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/sm4_pkg.sv =====
// sm4 package: request/result types, s-box, key constants, round functions
// no dependencies
`default_nettype none

package sm4_pkg;

	localparam int unsigned NumRounds = 32;
	localparam int unsigned RoundIdxW = $clog2(NumRounds);

	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic        decrypt;
	} req_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} rsp_t;

	localparam logic [31:0] FK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [31:0] CK [NumRounds] = '{
		32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
		32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
		32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
		32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
		32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
		32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
		32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
		32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] sub_word(input logic [31:0] v);
		sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	// round function for data: L(b) = b ^ b<<<2 ^ b<<<10 ^ b<<<18 ^ b<<<24
	function automatic logic [31:0] t_data(input logic [31:0] v);
		logic [31:0] b;
		b = sub_word(v);
		t_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
			^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
	endfunction

	// round function for key schedule: L'(b) = b ^ b<<<13 ^ b<<<23
	function automatic logic [31:0] t_key(input logic [31:0] v);
		logic [31:0] b;
		b = sub_word(v);
		t_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

endpackage

`default_nettype wire

// ===== src/sm4_block_cipher_unit.sv =====
// sm4 block cipher: iterative key schedule and 32-stage round pipeline
// depends on sm4_pkg and assert_macros.svh
//
// channel   direction  handshake             payload
// request   in         start & !busy         req (req_t)
// result    out        done, one cycle       result (rsp_t)
// key write in         cfg_write             cfg_index, cfg_data
//
// one block enters per cycle while busy is low; the result comes out of the input
// register and then one round per pipeline stage
// a key write starts the key schedule: one round key per cycle with busy high
// until every round key is written, then requests are taken again
// reset clears the pipeline valid bits, the key registers and the schedule counter
// and flag; round keys are undefined until the first key write
// the receiver cannot stall, so the pipeline never holds
`default_nettype none

module sm4_block_cipher_unit
	import sm4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        req,
	output logic             done,
	output rsp_t             result,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [63:0] cfg_data
);

`include "assert_macros.svh"

	localparam logic [RoundIdxW-1:0] LastRound = RoundIdxW'(NumRounds - 1);

	// key registers and key schedule
	logic [63:0]          key_high_q;
	logic [63:0]          key_low_q;
	logic [31:0]          kwin_q [4];
	logic [RoundIdxW-1:0] kcnt_q;
	logic                 expanding_q;
	logic [31:0]          rk_q [NumRounds];
	logic [63:0]          new_high;
	logic [63:0]          new_low;
	logic [31:0]          knext;

	always_comb begin
		new_high = key_high_q;
		new_low  = key_low_q;
		case (cfg_index)
			REG_KEY_HIGH: begin
				new_high = cfg_data;
			end
			REG_KEY_LOW: begin
				new_low = cfg_data;
			end
			default: begin
				new_high = key_high_q;
			end
		endcase
	end

	assign knext = kwin_q[0] ^ t_key(kwin_q[1] ^ kwin_q[2] ^ kwin_q[3] ^ CK[kcnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q  <= '0;
			key_low_q   <= '0;
			kcnt_q      <= '0;
			expanding_q <= 1'b0;
		end else if (cfg_write) begin
			key_high_q  <= new_high;
			key_low_q   <= new_low;
			kcnt_q      <= '0;
			expanding_q <= 1'b1;
		end else if (expanding_q) begin
			kcnt_q <= kcnt_q + RoundIdxW'(1);
			if (kcnt_q == LastRound) begin
				expanding_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_write) begin
			kwin_q[0] <= new_high[63:32] ^ FK[0];
			kwin_q[1] <= new_high[31:0]  ^ FK[1];
			kwin_q[2] <= new_low[63:32]  ^ FK[2];
			kwin_q[3] <= new_low[31:0]   ^ FK[3];
		end else if (expanding_q) begin
			kwin_q[0] <= kwin_q[1];
			kwin_q[1] <= kwin_q[2];
			kwin_q[2] <= kwin_q[3];
			kwin_q[3] <= knext;
			rk_q[kcnt_q] <= knext;
		end
	end

	assign busy = expanding_q;

	// round pipeline: stage i holds words x(i)..x(i+3)
	logic        vld_s [NumRounds+1];
	logic        dec_s [NumRounds+1];
	logic [31:0] x_s   [NumRounds+1][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0][0] <= req.block_high[63:32];
		x_s[0][1] <= req.block_high[31:0];
		x_s[0][2] <= req.block_low[63:32];
		x_s[0][3] <= req.block_low[31:0];
		dec_s[0]  <= req.decrypt;
	end

	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		logic [31:0] rk;
		logic [31:0] nx;

		assign rk = dec_s[i] ? rk_q[NumRounds-1-i] : rk_q[i];
		assign nx = x_s[i][0] ^ t_data(x_s[i][1] ^ x_s[i][2] ^ x_s[i][3] ^ rk);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1][0] <= x_s[i][1];
			x_s[i+1][1] <= x_s[i][2];
			x_s[i+1][2] <= x_s[i][3];
			x_s[i+1][3] <= nx;
			dec_s[i+1]  <= dec_s[i];
		end
	end

	// output in reversed word order
	assign done               = vld_s[NumRounds];
	assign result.result_high = {x_s[NumRounds][3], x_s[NumRounds][2]};
	assign result.result_low  = {x_s[NumRounds][1], x_s[NumRounds][0]};

	`ASSERT_NEXT(a_write_starts_schedule, clk, arst_n, cfg_write, busy)
	`ASSERT_NEXT(a_schedule_ends, clk, arst_n,
		busy && (kcnt_q == LastRound) && !cfg_write, !busy)
	`ASSERT_IMPLIES(a_idle_count_zero, clk, arst_n, !busy, kcnt_q == '0)

endmodule

`default_nettype wire

// ===== dv/tb_sm4_block_cipher_unit.sv =====
`timescale 1ns / 1ps
// testbench for sm4_block_cipher_unit: known vectors, then random blocks under changing keys
// results are checked against known outputs or an sm4 predictor here; depends on sm4_pkg

module tb_sm4_block_cipher_unit
	import sm4_pkg::*;
();

	localparam int unsigned RandItems = 1050;
	localparam int unsigned CalmTail = 150;
	localparam int unsigned DrainSlack = 40;
	localparam int unsigned DrainLimit = 4000;

	localparam logic [1:0] LOAD_NONE = 2'b00;
	localparam logic [1:0] LOAD_HIGH = 2'b01;
	localparam logic [1:0] LOAD_LOW  = 2'b10;
	localparam logic [1:0] LOAD_BOTH = 2'b11;

	typedef struct packed {
		logic [1:0]  load;
		logic [63:0] key_high;
		logic [63:0] key_low;
		req_t        blk;
		logic        typed;
		rsp_t        want;
	} vector_t;

	localparam logic [7:0] SboxLut [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,
		8'h28,8'hfb,8'h2c,8'h05,8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
		8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,8'h9c,8'h42,8'h50,8'hf4,
		8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,
		8'h75,8'h8f,8'h3f,8'ha6,8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
		8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,8'h68,8'h6b,8'h81,8'hb2,
		8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,
		8'h01,8'h21,8'h78,8'h87,8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
		8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,8'hea,8'hbf,8'h8a,8'hd2,
		8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,
		8'hf5,8'h8c,8'hb1,8'he3,8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
		8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,8'hd5,8'hdb,8'h37,8'h45,
		8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,
		8'h1f,8'h10,8'h5a,8'hd8,8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
		8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,8'h89,8'h69,8'h97,8'h4a,
		8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,
		8'hd7,8'hcb,8'h39,8'h48
	};

	localparam logic [31:0] FamilyKey [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	// standard test key and block, reused across rows
	localparam logic [63:0] StdHigh = 64'h0123456789abcdef;
	localparam logic [63:0] StdLow  = 64'hfedcba9876543210;
	localparam logic [63:0] CtHigh  = 64'h681edf34d206965e;
	localparam logic [63:0] CtLow   = 64'h86b3e94f536e4246;
	localparam logic [63:0] AllOnes = 64'hffffffffffffffff;
	localparam logic [63:0] AltA    = 64'haaaaaaaaaaaaaaaa;
	localparam logic [63:0] AltB    = 64'h5555555555555555;

	localparam vector_t KnownVectors [16] = '{
		'{LOAD_BOTH, StdHigh, StdLow, '{StdHigh, StdLow, 1'b0}, 1'b1, '{CtHigh, CtLow}},
		'{LOAD_NONE, '0, '0, '{CtHigh, CtLow, 1'b1}, 1'b1, '{StdHigh, StdLow}},
		'{LOAD_NONE, '0, '0, '{64'h0, 64'h0, 1'b0}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{AllOnes, AllOnes, 1'b0}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{64'h0, 64'h0, 1'b1}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{AllOnes, AllOnes, 1'b1}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{AltA, AltB, 1'b0}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{AltB, AltA, 1'b1}, 1'b0, '0},
		'{LOAD_BOTH, 64'h0, 64'h0, '{64'h0, 64'h0, 1'b0}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{AllOnes, AllOnes, 1'b1}, 1'b0, '0},
		'{LOAD_BOTH, AllOnes, AllOnes, '{AllOnes, AllOnes, 1'b0}, 1'b0, '0},
		'{LOAD_NONE, '0, '0, '{64'h0, 64'h0, 1'b1}, 1'b0, '0},
		// high half only, low half still all ones
		'{LOAD_HIGH, StdHigh, '0, '{StdHigh, StdLow, 1'b0}, 1'b0, '0},
		// low half only completes the standard key again
		'{LOAD_LOW, '0, StdLow, '{StdHigh, StdLow, 1'b0}, 1'b1, '{CtHigh, CtLow}},
		'{LOAD_NONE, '0, '0, '{64'h8000000000000001, 64'h0000000100000000, 1'b0}, 1'b0, '0},
		'{LOAD_LOW, '0, 64'h0, '{64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0, 1'b1}, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        done;
	rsp_t        result;
	logic        cfg_write;
	logic        cfg_index;
	logic [63:0] cfg_data;

	logic [63:0] key_high_copy;
	logic [63:0] key_low_copy;
	logic [31:0] round_key [32];
	rsp_t        expected_blocks [$];
	int          mismatches;

	sm4_block_cipher_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] v);
		return {SboxLut[v[31:24]], SboxLut[v[23:16]], SboxLut[v[15:8]], SboxLut[v[7:0]]};
	endfunction

	function automatic logic [31:0] data_mix(input logic [31:0] v);
		logic [31:0] b;
		b = sbox_word(v);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] key_mix(input logic [31:0] v);
		logic [31:0] b;
		b = sbox_word(v);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// byte j of chain word r is (4r + j) * 7 mod 256
	function automatic logic [31:0] chain_word(input int r);
		logic [31:0] w;
		for (int j = 0; j < 4; j++)
			w[31 - 8 * j -: 8] = 8'((4 * r + j) * 7);
		return w;
	endfunction

	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] nk;
		k[0] = key_high_copy[63:32] ^ FamilyKey[0];
		k[1] = key_high_copy[31:0] ^ FamilyKey[1];
		k[2] = key_low_copy[63:32] ^ FamilyKey[2];
		k[3] = key_low_copy[31:0] ^ FamilyKey[3];
		for (int r = 0; r < 32; r++) begin
			nk = k[0] ^ key_mix(k[1] ^ k[2] ^ k[3] ^ chain_word(r));
			round_key[r] = nk;
			k[0] = k[1];
			k[1] = k[2];
			k[2] = k[3];
			k[3] = nk;
		end
	endfunction

	function automatic rsp_t sm4_cipher(input req_t r);
		logic [31:0] x [4];
		logic [31:0] nx;
		logic [31:0] rk;
		rsp_t out;
		x[0] = r.block_high[63:32];
		x[1] = r.block_high[31:0];
		x[2] = r.block_low[63:32];
		x[3] = r.block_low[31:0];
		for (int i = 0; i < 32; i++) begin
			rk = r.decrypt ? round_key[31 - i] : round_key[i];
			nx = x[0] ^ data_mix(x[1] ^ x[2] ^ x[3] ^ rk);
			x[0] = x[1];
			x[1] = x[2];
			x[2] = x[3];
			x[3] = nx;
		end
		out.result_high = {x[3], x[2]};
		out.result_low = {x[1], x[0]};
		return out;
	endfunction

	// extremes now and then, and previous outputs fed back for round trips
	function automatic req_t random_block(input rsp_t prior);
		req_t r;
		case ($urandom_range(0, 9))
			0: begin
				r.block_high = '0;
				r.block_low = '0;
			end
			1: begin
				r.block_high = AllOnes;
				r.block_low = AllOnes;
			end
			2: begin
				r.block_high = prior.result_high;
				r.block_low = prior.result_low;
			end
			default: begin
				r.block_high = {$urandom, $urandom};
				r.block_low = {$urandom, $urandom};
			end
		endcase
		r.decrypt = 1'($urandom_range(0, 1));
		return r;
	endfunction

	task automatic load_key(input logic idx, input logic [63:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_KEY_HIGH)
			key_high_copy = value;
		else
			key_low_copy = value;
		expand_round_keys();
		// key schedule runs with busy high
		do @(posedge clk); while (!busy);
		while (busy) @(posedge clk);
	endtask

	task automatic load_keys(input logic [1:0] which, input logic [63:0] hi, input logic [63:0] lo);
		if ((which & LOAD_HIGH) != LOAD_NONE)
			load_key(REG_KEY_HIGH, hi);
		if ((which & LOAD_LOW) != LOAD_NONE)
			load_key(REG_KEY_LOW, lo);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
	endtask

	task automatic issue_block(input req_t r, input logic typed, input rsp_t want);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_blocks.push_back(typed ? want : sm4_cipher(r));
	endtask

	task automatic idle_gap(input bit allow);
		if (allow && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rsp_t oldest;
		if (arst_n && done) begin
			if (expected_blocks.size() == 0) begin
				$error("result with no request outstanding: %h", result);
				mismatches++;
			end else begin
				oldest = expected_blocks.pop_front();
				if (result.result_high !== oldest.result_high) begin
					$error("result_high: expected %h, got %h", oldest.result_high,
						result.result_high);
					mismatches++;
				end
				if (result.result_low !== oldest.result_low) begin
					$error("result_low: expected %h, got %h", oldest.result_low,
						result.result_low);
					mismatches++;
				end
			end
		end
	end

	initial begin
		rsp_t last_out;
		req_t blk;
		int sent;
		int phase_len;
		int waited;
		bit phase_idle;
		start = 1'b0;
		req = '0;
		cfg_write = 1'b0;
		cfg_index = REG_KEY_HIGH;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		key_high_copy = '0;
		key_low_copy = '0;
		last_out = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (KnownVectors[i]) begin
			if (KnownVectors[i].load != LOAD_NONE) begin
				drain_results();
				load_keys(KnownVectors[i].load, KnownVectors[i].key_high,
					KnownVectors[i].key_low);
			end
			issue_block(KnownVectors[i].blk, KnownVectors[i].typed, KnownVectors[i].want);
			idle_gap(1'b1);
		end

		sent = 0;
		while (sent < RandItems) begin
			// every phase starts from an empty pipeline
			drain_results();
			case ($urandom_range(0, 5))
				0: load_keys(LOAD_BOTH, {$urandom, $urandom}, {$urandom, $urandom});
				1: load_keys(LOAD_HIGH, {$urandom, $urandom}, '0);
				2: load_keys(LOAD_LOW, '0, {$urandom, $urandom});
				3: load_keys(LOAD_BOTH, '0, '0);
				4: load_keys(LOAD_BOTH, AllOnes, AllOnes);
				default: ;
			endcase
			if (RandItems - sent <= CalmTail)
				phase_len = RandItems - sent;
			else
				phase_len = $urandom_range(20, 120);
			phase_idle = $urandom_range(0, 2) != 0;
			for (int n = 0; n < phase_len && sent < RandItems; n++) begin
				blk = random_block(last_out);
				issue_block(blk, 1'b0, '0);
				last_out = expected_blocks[$];
				sent++;
				idle_gap(phase_idle && (RandItems - sent > CalmTail));
			end
		end

		start <= 1'b0;
		waited = 0;
		while (expected_blocks.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (DrainSlack) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			$error("%0d results never arrived", expected_blocks.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
